// File: rtl/cnre_pkg.sv
// Package of the change notify retry engine: status codes, opcodes,
// register indexes, table size and the sequencer state type. Used by all rtl files.
package cnre_pkg;

   localparam int unsigned MAX_PEERS = 16;
   localparam int unsigned PEER_IDX_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;

   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_MY_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PEER_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESP_TIMEOUT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUND_PAUSE = 2'd3;

   localparam logic [7:0] RESET_TIMEOUT = 8'd100;
   localparam logic [7:0] RESET_PAUSE = 8'd200;

   typedef enum logic [1:0] {
      OP_POLL = 2'd0,
      OP_CONFIRM = 2'd1,
      OP_LOAD = 2'd2,
      OP_NONE = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_INIT = 2'd0,
      ST_WAIT = 2'd1,
      ST_OK = 2'd2,
      ST_GIVEN_UP = 2'd3
   } status_type;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_CLEAR = 6'b000010,
      S_HANDLE = 6'b000100,
      S_SCAN = 6'b001000,
      S_CONFIRM = 6'b010000,
      S_DONE = 6'b100000
   } seq_state_type;

endpackage

// File: rtl/cnre_peer_table.sv
// Peer table of the change notify retry engine: address, retry limit, retry
// counter, status and time stamp of each entry. Depends on cnre_pkg.
module cnre_peer_table
   import cnre_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic load_en,
   input logic [PEER_IDX_W-1:0] load_idx,
   input logic [7:0] load_addr,
   input logic [7:0] load_limit,
   input logic upd_en,
   input logic [PEER_IDX_W-1:0] upd_idx,
   input status_type upd_status,
   input logic [7:0] upd_count,
   input logic upd_stamp_en,
   input logic [15:0] upd_stamp,
   input logic [PEER_IDX_W-1:0] rd_idx,
   output logic [7:0] rd_addr,
   output logic [7:0] rd_limit,
   output logic [7:0] rd_count,
   output status_type rd_status,
   output logic [15:0] rd_stamp
);

   logic [7:0] addr_ff [MAX_PEERS];
   logic [7:0] limit_ff [MAX_PEERS];
   logic [7:0] count_ff [MAX_PEERS];
   status_type status_ff [MAX_PEERS];
   logic [15:0] stamp_ff [MAX_PEERS];

   always_ff @(posedge clock) begin
      if (load_en) begin
         addr_ff[load_idx] <= load_addr;
         limit_ff[load_idx] <= load_limit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PEERS; i++) begin
            count_ff[i] <= '0;
            status_ff[i] <= ST_INIT;
            stamp_ff[i] <= '0;
         end
      end else if (upd_en) begin
         count_ff[upd_idx] <= upd_count;
         status_ff[upd_idx] <= upd_status;
         if (upd_stamp_en) begin
            stamp_ff[upd_idx] <= upd_stamp;
         end
      end
   end

   assign rd_addr = addr_ff[rd_idx];
   assign rd_limit = limit_ff[rd_idx];
   assign rd_count = count_ff[rd_idx];
   assign rd_status = status_ff[rd_idx];
   assign rd_stamp = stamp_ff[rd_idx];

endmodule

// File: rtl/change_notify_retry_engine_top.sv
// Top level of the change notify retry engine: request handshake, sequencer
// and configuration registers. Depends on cnre_pkg and cnre_peer_table.
//
// Within a request the table entries are visited one at a time: a state
// change clears the valid entries one per cycle, the next-peer scan and a
// confirmation search each step through the table one entry per cycle over
// the single table read port.
// One request is handled at a time; the response is held in an output
// register until taken.
module change_notify_retry_engine_top
   import cnre_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [1:0] req_opcode,
   input logic [15:0] req_time_ms,
   input logic [7:0] req_io_state,
   input logic req_bus_ready,
   input logic [7:0] req_peer_address,
   input logic [7:0] req_receiver_address,
   input logic [7:0] req_reported_state,
   input logic [3:0] req_entry_index,
   input logic [7:0] req_entry_max_retry,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic rsp_send_valid,
   output logic [7:0] rsp_dest_address,
   output logic [7:0] rsp_event_state,
   output logic rsp_round_active,
   input logic csr_write,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0] csr_data
);

   localparam int unsigned IDX_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_PEERS + 1);
   localparam logic [4:0] MAXP5 = 5'(MAX_PEERS);

   logic [7:0] my_addr_ff;
   logic [4:0] peer_count_ff;
   logic [15:0] timeout_ff;
   logic [15:0] pause_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         my_addr_ff <= '0;
         peer_count_ff <= '0;
         timeout_ff <= {8'd0, RESET_TIMEOUT};
         pause_ff <= {8'd0, RESET_PAUSE};
      end else if (csr_write) begin
         case (csr_index)
            CSR_MY_ADDRESS: my_addr_ff <= csr_data[7:0];
            CSR_PEER_COUNT: peer_count_ff <= csr_data[4:0];
            CSR_RESP_TIMEOUT: timeout_ff <= csr_data;
            CSR_ROUND_PAUSE: pause_ff <= csr_data;
            default: ;
         endcase
      end
   end

   seq_state_type state_ff, state_in;
   logic [1:0] op_ff;
   logic [15:0] time_ff;
   logic [7:0] io_ff, peer_ff, rep_ff;
   logic ready_ff;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0] cur_ff, cur_in;
   logic round_ff, round_in;
   logic [7:0] last_ff, last_in;
   logic seen_ff, seen_in;
   logic pend_ff, pend_in;
   logic [15:0] pstamp_ff, pstamp_in;
   logic send_ff, send_in;
   logic [7:0] dest_ff, dest_in, evs_ff, evs_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [IDX_W-1:0] rd_idx;
   logic [7:0] rd_addr, rd_limit, rd_count;
   status_type rd_status;
   logic [15:0] rd_stamp;
   logic upd_en, upd_stamp_en;
   logic [IDX_W-1:0] upd_idx;
   status_type upd_status;
   logic [7:0] upd_count;
   logic load_en;

   logic accept;
   logic [CNT_W-1:0] n_calc;
   logic [CNT_W-1:0] nxt_idx;
   logic [15:0] tdiff;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign n_calc = (peer_count_ff > MAXP5) ? CNT_W'(MAX_PEERS) : CNT_W'(peer_count_ff);
   assign load_en = accept && (opcode_type'(req_opcode) == OP_LOAD)
                    && ({1'b0, req_entry_index} < 5'(MAX_PEERS));

   assign nxt_idx = (ptr_ff + CNT_W'(1) >= n_ff) ? '0 : ptr_ff + CNT_W'(1);
   assign tdiff = time_ff - rd_stamp;

   cnre_peer_table u_table (
      .clock(clock),
      .reset(reset),
      .load_en(load_en),
      .load_idx(req_entry_index[IDX_W-1:0]),
      .load_addr(req_peer_address),
      .load_limit(req_entry_max_retry),
      .upd_en(upd_en),
      .upd_idx(upd_idx),
      .upd_status(upd_status),
      .upd_count(upd_count),
      .upd_stamp_en(upd_stamp_en),
      .upd_stamp(time_ff),
      .rd_idx(rd_idx),
      .rd_addr(rd_addr),
      .rd_limit(rd_limit),
      .rd_count(rd_count),
      .rd_status(rd_status),
      .rd_stamp(rd_stamp)
   );

   always_comb begin
      state_in = state_ff;
      n_in = n_ff;
      ptr_in = ptr_ff;
      step_in = step_ff;
      cur_in = cur_ff;
      round_in = round_ff;
      last_in = last_ff;
      seen_in = seen_ff;
      pend_in = pend_ff;
      pstamp_in = pstamp_ff;
      send_in = send_ff;
      dest_in = dest_ff;
      evs_in = evs_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_idx = ptr_ff[IDX_W-1:0];
      upd_en = 1'b0;
      upd_stamp_en = 1'b0;
      upd_idx = ptr_ff[IDX_W-1:0];
      upd_status = ST_INIT;
      upd_count = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               send_in = 1'b0;
               dest_in = '0;
               evs_in = '0;
               n_in = n_calc;
               ptr_in = '0;
               case (opcode_type'(req_opcode))
                  OP_POLL: begin
                     if (n_calc == '0) begin
                        state_in = S_DONE;
                     end else if (!seen_ff || req_io_state != last_ff) begin
                        last_in = req_io_state;
                        seen_in = 1'b1;
                        cur_in = '0;
                        round_in = 1'b1;
                        pend_in = 1'b0;
                        state_in = S_CLEAR;
                     end else begin
                        ptr_in = cur_ff;
                        state_in = S_HANDLE;
                     end
                  end
                  OP_CONFIRM: begin
                     state_in = (req_receiver_address == my_addr_ff && n_calc != '0)
                                ? S_CONFIRM : S_DONE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_CLEAR: begin
            upd_en = 1'b1;
            upd_status = ST_INIT;
            upd_count = '0;
            if (ptr_ff + CNT_W'(1) >= n_ff) begin
               ptr_in = '0;
               state_in = S_HANDLE;
            end else begin
               ptr_in = ptr_ff + CNT_W'(1);
            end
         end
         S_HANDLE: begin
            rd_idx = cur_ff[IDX_W-1:0];
            upd_idx = cur_ff[IDX_W-1:0];
            state_in = S_DONE;
            if (!round_ff) begin
               state_in = S_DONE;
            end else if (pend_ff && (time_ff - pstamp_ff) < pause_ff) begin
               state_in = S_DONE;
            end else begin
               pend_in = 1'b0;
               if (cur_ff >= n_ff) begin
                  round_in = 1'b0;
               end else begin
                  ptr_in = cur_ff;
                  step_in = '0;
                  state_in = S_SCAN;
                  case (rd_status)
                     ST_INIT: begin
                        if (ready_ff) begin
                           send_in = 1'b1;
                           dest_in = rd_addr;
                           evs_in = io_ff;
                           upd_en = 1'b1;
                           upd_stamp_en = 1'b1;
                           upd_status = ST_WAIT;
                           upd_count = rd_count;
                        end else begin
                           state_in = S_DONE;
                        end
                     end
                     ST_WAIT: begin
                        if (tdiff >= timeout_ff) begin
                           upd_en = 1'b1;
                           if (rd_count < rd_limit) begin
                              upd_count = rd_count + 8'd1;
                              upd_status = ST_INIT;
                              state_in = S_DONE;
                           end else begin
                              upd_count = rd_count;
                              upd_status = ST_GIVEN_UP;
                           end
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
         S_SCAN: begin
            rd_idx = nxt_idx[IDX_W-1:0];
            if (rd_status == ST_INIT || rd_status == ST_WAIT) begin
               if (nxt_idx <= cur_ff) begin
                  pend_in = 1'b1;
                  pstamp_in = time_ff;
               end
               cur_in = nxt_idx;
               state_in = S_DONE;
            end else if (step_ff + CNT_W'(1) >= n_ff) begin
               round_in = 1'b0;
               state_in = S_DONE;
            end else begin
               ptr_in = nxt_idx;
               step_in = step_ff + CNT_W'(1);
            end
         end
         S_CONFIRM: begin
            if (rd_addr == peer_ff && rd_status == ST_WAIT) begin
               if (rep_ff == last_ff) begin
                  upd_en = 1'b1;
                  upd_status = ST_OK;
                  upd_count = rd_count;
               end
               state_in = S_DONE;
            end else if (ptr_ff + CNT_W'(1) >= n_ff) begin
               state_in = S_DONE;
            end else begin
               ptr_in = ptr_ff + CNT_W'(1);
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         round_ff <= 1'b0;
         seen_ff <= 1'b0;
         pend_ff <= 1'b0;
         last_ff <= '0;
         pstamp_ff <= '0;
         cur_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         seen_ff <= seen_in;
         pend_ff <= pend_in;
         last_ff <= last_in;
         pstamp_ff <= pstamp_in;
         cur_ff <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      ptr_ff <= ptr_in;
      step_ff <= step_in;
      send_ff <= send_in;
      dest_ff <= dest_in;
      evs_ff <= evs_in;
      if (accept) begin
         op_ff <= req_opcode;
         time_ff <= req_time_ms;
         io_ff <= req_io_state;
         ready_ff <= req_bus_ready;
         peer_ff <= req_peer_address;
         rep_ff <= req_reported_state;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_send_valid = send_ff && (opcode_type'(op_ff) == OP_POLL);
   assign rsp_dest_address = dest_ff;
   assign rsp_event_state = evs_ff;
   assign rsp_round_active = round_ff;

endmodule
